// ===== src/olist_pkg.sv =====
`default_nettype none

package olist_pkg;

  // Fixed field widths
  localparam int unsigned ValW    = 32;
  localparam int unsigned PosW    = 8;
  localparam int unsigned KindW   = 2;
  localparam int unsigned StatusW = 3;

  // Default list capacity
  localparam int unsigned DefCapacity = 32;

  typedef enum logic [KindW-1:0] {
    KIND_APPEND = 2'd0,
    KIND_DELETE = 2'd1,
    KIND_INSERT = 2'd2,
    KIND_DUMP   = 2'd3
  } kind_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK        = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_RANGE     = 3'd3,
    ST_FULL      = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RESP,
    S_DEL_SCAN,
    S_INS_SHIFT,
    S_INS_PUT,
    S_DUMP_EMIT
  } state_e;

endpackage

`default_nettype wire

// ===== src/olist_if.sv =====
`default_nettype none

// Request channel: one list operation per transaction
interface olist_req_if;
  logic                                valid;
  logic                                ready;
  logic [olist_pkg::KindW-1:0]         kind;
  logic signed [olist_pkg::ValW-1:0]   entry_value;
  logic [olist_pkg::PosW-1:0]          position;

  modport source (output valid, output kind, output entry_value, output position,
                  input ready);
  modport sink   (input valid, input kind, input entry_value, input position,
                  output ready);
endinterface

// Result channel: one status or dumped entry per transaction
interface olist_res_if;
  logic                                valid;
  logic                                ready;
  logic [olist_pkg::StatusW-1:0]       status;
  logic signed [olist_pkg::ValW-1:0]   entry_value_res;
  logic                                last;

  modport source (output valid, output status, output entry_value_res, output last,
                  input ready);
  modport sink   (input valid, input status, input entry_value_res, input last,
                  output ready);
endinterface

`default_nettype wire

// ===== src/olist_mem.sv =====
`default_nettype none

module olist_mem #(
  parameter  int unsigned Depth = olist_pkg::DefCapacity,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic                        clk_i,
  input  wire logic                        re_i,
  input  wire logic [AddrW-1:0]            raddr_i,
  output logic [olist_pkg::ValW-1:0]       rdata_o,
  input  wire logic                        we_i,
  input  wire logic [AddrW-1:0]            waddr_i,
  input  wire logic [olist_pkg::ValW-1:0]  wdata_i
);

  logic [olist_pkg::ValW-1:0] mem_q [Depth];
  logic [olist_pkg::ValW-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port; data holds until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== src/olist_ctrl.sv =====
`default_nettype none

module olist_ctrl #(
  parameter  int unsigned Capacity = olist_pkg::DefCapacity,
  localparam int unsigned AddrW    = (Capacity > 1) ? $clog2(Capacity) : 1,
  localparam int unsigned LenW     = $clog2(Capacity + 1)
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  olist_req_if.sink                        req_i,
  olist_res_if.source                      res_o,
  output logic                             mem_re_o,
  output logic [AddrW-1:0]                 mem_raddr_o,
  input  wire logic [olist_pkg::ValW-1:0]  mem_rdata_i,
  output logic                             mem_we_o,
  output logic [AddrW-1:0]                 mem_waddr_o,
  output logic [olist_pkg::ValW-1:0]       mem_wdata_o
);

  localparam int unsigned PW = olist_pkg::PosW;
  localparam int unsigned VW = olist_pkg::ValW;

  olist_pkg::state_e  state_q, state_d;
  olist_pkg::status_e st_q, st_d;
  logic [LenW-1:0]    len_q, len_d;
  logic [LenW-1:0]    idx_q, idx_d;
  logic               pend_q, pend_d;
  logic               found_q, found_d;
  logic [VW-1:0]      val_q, val_d;
  logic [PW-1:0]      pos_q, pos_d;

  logic                     out_valid_q, out_valid_d;
  olist_pkg::status_e       out_status_q, out_status_d;
  logic [VW-1:0]            out_value_q, out_value_d;
  logic                     out_last_q, out_last_d;

  logic            accept;
  logic            slot_free;
  logic            full;
  logic            match;
  logic [LenW-1:0] idx_dec;
  logic [LenW-1:0] idx_inc;
  logic [LenW-1:0] idx_back2;
  logic [LenW-1:0] len_dec;
  olist_pkg::kind_e kind_in;

  assign accept    = req_i.valid && (state_q == olist_pkg::S_IDLE);
  assign slot_free = !out_valid_q || res_o.ready;
  assign full      = (len_q == LenW'(Capacity));
  assign match     = (mem_rdata_i == val_q);
  assign idx_dec   = idx_q - LenW'(1);
  assign idx_inc   = idx_q + LenW'(1);
  assign idx_back2 = idx_q - LenW'(2);
  assign len_dec   = len_q - LenW'(1);
  assign kind_in   = olist_pkg::kind_e'(req_i.kind);

  // Next state, memory accesses and result loading
  always_comb begin
    state_d      = state_q;
    st_d         = st_q;
    len_d        = len_q;
    idx_d        = idx_q;
    pend_d       = pend_q;
    found_d      = found_q;
    val_d        = val_q;
    pos_d        = pos_q;
    out_valid_d  = out_valid_q && !res_o.ready;
    out_status_d = out_status_q;
    out_value_d  = out_value_q;
    out_last_d   = out_last_q;
    mem_re_o     = 1'b0;
    mem_raddr_o  = '0;
    mem_we_o     = 1'b0;
    mem_waddr_o  = '0;
    mem_wdata_o  = '0;
    req_i.ready  = 1'b0;

    case (state_q)
      olist_pkg::S_IDLE: begin
        req_i.ready = 1'b1;
        if (accept) begin
          val_d = req_i.entry_value;
          pos_d = req_i.position;
          case (kind_in)
            olist_pkg::KIND_APPEND: begin
              state_d = olist_pkg::S_RESP;
              if (full) begin
                st_d = olist_pkg::ST_FULL;
              end else begin
                mem_we_o    = 1'b1;
                mem_waddr_o = len_q[AddrW-1:0];
                mem_wdata_o = req_i.entry_value;
                len_d       = len_q + LenW'(1);
                st_d        = olist_pkg::ST_OK;
              end
            end
            olist_pkg::KIND_DELETE: begin
              if (len_q == '0) begin
                st_d    = olist_pkg::ST_EMPTY;
                state_d = olist_pkg::S_RESP;
              end else begin
                mem_re_o    = 1'b1;
                mem_raddr_o = '0;
                idx_d       = LenW'(1);
                found_d     = 1'b0;
                state_d     = olist_pkg::S_DEL_SCAN;
              end
            end
            olist_pkg::KIND_INSERT: begin
              if (req_i.position > PW'(len_q)) begin
                st_d    = olist_pkg::ST_RANGE;
                state_d = olist_pkg::S_RESP;
              end else if (full) begin
                st_d    = olist_pkg::ST_FULL;
                state_d = olist_pkg::S_RESP;
              end else begin
                idx_d   = len_q;
                pend_d  = 1'b0;
                state_d = olist_pkg::S_INS_SHIFT;
              end
            end
            default: begin
              if (len_q == '0) begin
                st_d    = olist_pkg::ST_EMPTY;
                state_d = olist_pkg::S_RESP;
              end else begin
                mem_re_o    = 1'b1;
                mem_raddr_o = '0;
                idx_d       = '0;
                state_d     = olist_pkg::S_DUMP_EMIT;
              end
            end
          endcase
        end
      end

      // Emit a single status result
      olist_pkg::S_RESP: begin
        if (slot_free) begin
          out_valid_d  = 1'b1;
          out_status_d = st_q;
          out_value_d  = '0;
          out_last_d   = 1'b1;
          state_d      = olist_pkg::S_IDLE;
        end
      end

      // Compare entry idx-1; once matched, move each later entry up by one
      olist_pkg::S_DEL_SCAN: begin
        if (found_q) begin
          mem_we_o    = 1'b1;
          mem_waddr_o = idx_back2[AddrW-1:0];
          mem_wdata_o = mem_rdata_i;
        end else if (match) begin
          found_d = 1'b1;
        end
        if (idx_q < len_q) begin
          mem_re_o    = 1'b1;
          mem_raddr_o = idx_q[AddrW-1:0];
          idx_d       = idx_inc;
        end else begin
          state_d = olist_pkg::S_RESP;
          if (found_q || match) begin
            len_d = len_dec;
            st_d  = olist_pkg::ST_OK;
          end else begin
            st_d = olist_pkg::ST_NOT_FOUND;
          end
        end
      end

      // Move entries from the tail down to pos one place back
      olist_pkg::S_INS_SHIFT: begin
        if (pend_q) begin
          mem_we_o    = 1'b1;
          mem_waddr_o = idx_inc[AddrW-1:0];
          mem_wdata_o = mem_rdata_i;
        end
        if (PW'(idx_q) > pos_q) begin
          mem_re_o    = 1'b1;
          mem_raddr_o = idx_dec[AddrW-1:0];
          idx_d       = idx_dec;
          pend_d      = 1'b1;
        end else begin
          pend_d  = 1'b0;
          state_d = olist_pkg::S_INS_PUT;
        end
      end

      // Place the new value in the opened slot
      olist_pkg::S_INS_PUT: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = pos_q[AddrW-1:0];
        mem_wdata_o = val_q;
        len_d       = len_q + LenW'(1);
        st_d        = olist_pkg::ST_OK;
        state_d     = olist_pkg::S_RESP;
      end

      // Emit entry idx from read data, then fetch the next
      olist_pkg::S_DUMP_EMIT: begin
        if (slot_free) begin
          out_valid_d  = 1'b1;
          out_status_d = olist_pkg::ST_OK;
          out_value_d  = mem_rdata_i;
          out_last_d   = (idx_q == len_dec);
          if (idx_q == len_dec) begin
            state_d = olist_pkg::S_IDLE;
          end else begin
            mem_re_o    = 1'b1;
            mem_raddr_o = idx_inc[AddrW-1:0];
            idx_d       = idx_inc;
          end
        end
      end

      default: begin
        state_d = olist_pkg::S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= olist_pkg::S_IDLE;
      len_q       <= '0;
      pend_q      <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      pend_q      <= pend_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    st_q         <= st_d;
    idx_q        <= idx_d;
    val_q        <= val_d;
    pos_q        <= pos_d;
    out_status_q <= out_status_d;
    out_value_q  <= out_value_d;
    out_last_q   <= out_last_d;
  end

  assign res_o.valid           = out_valid_q;
  assign res_o.status          = out_status_q;
  assign res_o.entry_value_res = out_value_q;
  assign res_o.last            = out_last_q;

endmodule

`default_nettype wire

// ===== src/ordered_value_list_core.sv =====
`default_nettype none

// Channel  Dir  Payload                              Handshake
// req_i    in   kind, entry_value, position          valid/ready
// res_o    out  status, entry_value_res, last        valid/ready
//
// Append writes its entry at once; delete, insert and dump walk the entries
// through the entry memory, which has one read port and one write port, and
// a stalled output holds each result until it is taken.
// Reset clears the length and control state only; entries need no clearing.
// A new request is taken while the last result still waits in the output
// register; a stalled output holds the dump walk in place.

module ordered_value_list_core #(
  parameter int unsigned CAPACITY = olist_pkg::DefCapacity
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  olist_req_if.sink   req_i,
  olist_res_if.source res_o
);

  localparam int unsigned AddrW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  logic                       mem_re;
  logic [AddrW-1:0]           mem_raddr;
  logic [olist_pkg::ValW-1:0] mem_rdata;
  logic                       mem_we;
  logic [AddrW-1:0]           mem_waddr;
  logic [olist_pkg::ValW-1:0] mem_wdata;

  // Sequencer for all list operations
  olist_ctrl #(
    .Capacity (CAPACITY)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .res_o       (res_o),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata)
  );

  // Entry storage
  olist_mem #(
    .Depth (CAPACITY)
  ) u_mem (
    .clk_i   (clk_i),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata)
  );

endmodule

`default_nettype wire

// ===== tb/sv/ordered_value_list_core_test.sv =====
`default_nettype none

module ordered_value_list_core_test;

  localparam int unsigned ListCap = olist_pkg::DefCapacity;

  typedef struct packed {
    olist_pkg::status_e status;
    logic [31:0]        value;
    logic               last;
  } list_result_t;

  logic clk;
  logic rst_n;

  olist_req_if req_if ();
  olist_res_if res_if ();

  ordered_value_list_core #(
    .CAPACITY(ListCap)
  ) dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req_i (req_if),
    .res_o (res_if)
  );

  // Shadow copy of the list, updated as each request transaction is accepted
  logic [31:0]  model_entries [ListCap];
  int unsigned  model_len;
  list_result_t list_results_due[$];

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned mismatch_count;
  bit          grow_list;

  always #5 clk = ~clk;

  // Hard stop in case the block hangs
  initial begin
    #20_000_000;
    $display("FAIL ordered_value_list_core");
    $finish;
  end

  function automatic void expect_status(olist_pkg::status_e st);
    list_results_due.push_back(list_result_t'{st, 32'd0, 1'b1});
  endfunction

  // Work out the results one request causes and advance the shadow list
  function automatic void apply_list_request(olist_pkg::kind_e k, logic [31:0] v,
                                             logic [7:0] p);
    int unsigned idx;
    case (k)
      olist_pkg::KIND_APPEND: begin
        if (model_len >= ListCap) begin
          expect_status(olist_pkg::ST_FULL);
        end else begin
          model_entries[model_len] = v;
          model_len++;
          expect_status(olist_pkg::ST_OK);
        end
      end
      olist_pkg::KIND_DELETE: begin
        if (model_len == 0) begin
          expect_status(olist_pkg::ST_EMPTY);
        end else begin
          idx = 0;
          while (idx < model_len && model_entries[idx] != v) idx++;
          if (idx == model_len) begin
            expect_status(olist_pkg::ST_NOT_FOUND);
          end else begin
            for (; idx + 1 < model_len; idx++) model_entries[idx] = model_entries[idx + 1];
            model_len--;
            expect_status(olist_pkg::ST_OK);
          end
        end
      end
      olist_pkg::KIND_INSERT: begin
        if (p > model_len) begin
          expect_status(olist_pkg::ST_RANGE);
        end else if (model_len >= ListCap) begin
          expect_status(olist_pkg::ST_FULL);
        end else begin
          for (idx = model_len; idx > p; idx--) model_entries[idx] = model_entries[idx - 1];
          model_entries[p] = v;
          model_len++;
          expect_status(olist_pkg::ST_OK);
        end
      end
      default: begin
        if (model_len == 0) begin
          expect_status(olist_pkg::ST_EMPTY);
        end else begin
          for (idx = 0; idx < model_len; idx++) begin
            list_results_due.push_back(list_result_t'{olist_pkg::ST_OK, model_entries[idx],
                                                      idx + 1 == model_len});
          end
        end
      end
    endcase
  endfunction

  // Present one request, hold it until accepted, then predict its results
  task automatic send_list_request(olist_pkg::kind_e k, logic [31:0] v, logic [7:0] p);
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid       <= 1'b1;
    req_if.kind        <= k;
    req_if.entry_value <= v;
    req_if.position    <= p;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    apply_list_request(k, v, p);
  endtask

  // Hold off new requests until every predicted result has arrived
  task automatic wait_results_drained();
    req_if.valid <= 1'b0;
    while (list_results_due.size() != 0) @(posedge clk);
  endtask

  // Mix of extremes, a small pool for duplicates, and full random patterns
  function automatic logic [31:0] pick_value();
    case ($urandom_range(9))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      4, 5:    return $urandom_range(7);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_random_request();
    int unsigned      roll;
    olist_pkg::kind_e k;
    logic [31:0]      v;
    logic [7:0]       p;
    roll = $urandom_range(99);
    v    = pick_value();
    if ($urandom_range(9) < 8) p = 8'($urandom_range(model_len));
    else p = 8'($urandom_range(255));
    if (roll < 10) k = olist_pkg::KIND_DUMP;
    else if (grow_list) k = (roll < 55) ? olist_pkg::KIND_APPEND :
                            (roll < 85) ? olist_pkg::KIND_INSERT : olist_pkg::KIND_DELETE;
    else k = (roll < 20) ? olist_pkg::KIND_APPEND :
             (roll < 30) ? olist_pkg::KIND_INSERT : olist_pkg::KIND_DELETE;
    // Mostly delete values that are present so entries really get removed
    if (k == olist_pkg::KIND_DELETE && model_len > 0 && $urandom_range(3) != 0) begin
      v = model_entries[$urandom_range(model_len - 1)];
    end
    send_list_request(k, v, p);
  endtask

  // Empty-list responses and position checks before anything is stored
  task automatic test_empty_list();
    send_list_request(olist_pkg::KIND_DELETE, 32'd0, 8'd0);
    send_list_request(olist_pkg::KIND_DUMP, 32'hFFFF_FFFF, 8'hFF);
    send_list_request(olist_pkg::KIND_INSERT, 32'h1, 8'd1);
    send_list_request(olist_pkg::KIND_INSERT, 32'h2, 8'hFF);
  endtask

  // Extreme values, head/middle/tail edits, first-match delete
  task automatic test_edge_values();
    send_list_request(olist_pkg::KIND_INSERT, 32'h8000_0000, 8'd0);
    send_list_request(olist_pkg::KIND_APPEND, 32'h7FFF_FFFF, 8'h00);
    send_list_request(olist_pkg::KIND_APPEND, 32'hFFFF_FFFF, 8'hFF);
    send_list_request(olist_pkg::KIND_APPEND, 32'h0000_0000, 8'h55);
    send_list_request(olist_pkg::KIND_INSERT, 32'h0000_0001, 8'd4);
    send_list_request(olist_pkg::KIND_INSERT, 32'hFFFF_FFFF, 8'd2);
    send_list_request(olist_pkg::KIND_DUMP, 32'd0, 8'd0);
    send_list_request(olist_pkg::KIND_DELETE, 32'h1234_5678, 8'd0);
    send_list_request(olist_pkg::KIND_DELETE, 32'hFFFF_FFFF, 8'd0);
    send_list_request(olist_pkg::KIND_DELETE, 32'h8000_0000, 8'd0);
    send_list_request(olist_pkg::KIND_DELETE, 32'h0000_0001, 8'd0);
    send_list_request(olist_pkg::KIND_INSERT, 32'hA5A5_A5A5, 8'hAA);
    send_list_request(olist_pkg::KIND_DUMP, 32'd0, 8'd0);
    wait_results_drained();
  endtask

  // Fill the list, then hit the full and out-of-range limits and dump it all
  task automatic test_fill_to_capacity();
    while (model_len < ListCap) begin
      if ($urandom_range(1) == 0) begin
        send_list_request(olist_pkg::KIND_APPEND, pick_value(), 8'($urandom));
      end else begin
        send_list_request(olist_pkg::KIND_INSERT, pick_value(),
                          8'($urandom_range(model_len)));
      end
    end
    send_list_request(olist_pkg::KIND_APPEND, 32'h7FFF_FFFF, 8'd0);
    send_list_request(olist_pkg::KIND_INSERT, 32'h8000_0000, 8'(ListCap));
    send_list_request(olist_pkg::KIND_INSERT, 32'h8000_0000, 8'd0);
    send_list_request(olist_pkg::KIND_INSERT, 32'h8000_0000, 8'(ListCap + 1));
    send_list_request(olist_pkg::KIND_DUMP, 32'd0, 8'd0);
    grow_list = 1'b0;
  endtask

  // Let the list swing between empty and full with random content
  task automatic test_random_traffic(int unsigned count);
    repeat (count) begin
      if (model_len == ListCap && $urandom_range(3) == 0) grow_list = 1'b0;
      if (model_len == 0) grow_list = 1'b1;
      send_random_request();
    end
  endtask

  // Accept results with random stalls and compare each with the oldest prediction
  always @(posedge clk) begin
    list_result_t want;
    if (rst_n && res_if.valid && res_if.ready) begin
      if (list_results_due.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("unexpected result: status %0d value %h last %b",
                   res_if.status, res_if.entry_value_res, res_if.last);
        end
      end else begin
        want = list_results_due.pop_front();
        if (res_if.status !== want.status || res_if.entry_value_res !== want.value ||
            res_if.last !== want.last) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("result mismatch: status %0d/%0d value %h/%h last %b/%b (expected/actual)",
                     want.status, res_if.status, want.value, res_if.entry_value_res,
                     want.last, res_if.last);
          end
        end
      end
    end
    res_if.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  initial begin
    clk                = 1'b0;
    rst_n              = 1'b0;
    req_if.valid       = 1'b0;
    req_if.kind        = olist_pkg::KIND_APPEND;
    req_if.entry_value = '0;
    req_if.position    = '0;
    res_if.ready       = 1'b0;
    model_len          = 0;
    mismatch_count     = 0;
    grow_list          = 1'b1;
    send_idle_pct      = 13;
    recv_idle_pct      = 61;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_list();
    test_edge_values();
    test_fill_to_capacity();
    test_random_traffic(100);

    send_idle_pct = 61;
    recv_idle_pct = 13;
    test_random_traffic(110);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(110);

    // Drain and give the block time to show any stray result
    wait_results_drained();
    repeat (ListCap + 8) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("PASS ordered_value_list_core");
    end else begin
      $display("FAIL ordered_value_list_core");
    end
    $finish;
  end

endmodule

`default_nettype wire
